>>> design/ftc_pkg.sv
// shared constants, types and codes of the fuzzy trapezoid controller
package ftc_pkg;

    localparam int POINT_W   = 16;
    localparam int IN_SETS   = 8;
    localparam int OUT_SETS  = 8;
    localparam int RULES     = 8;
    localparam int IN_IW     = $clog2(IN_SETS);
    localparam int OUT_IW    = $clog2(OUT_SETS);
    localparam int RULE_IW   = $clog2(RULES);
    localparam int CNT_W     = $clog2(IN_SETS + 1);
    localparam int OCNT_W    = $clog2(OUT_SETS + 1);
    localparam int RCNT_W    = $clog2(RULES + 1);
    localparam int OP_W      = 3;
    localparam int RIDX_W    = 3;
    localparam int STAT_W    = 2;
    localparam int FRAC_W    = 16;
    localparam int MU_W      = FRAC_W + 1;
    localparam int DIFF_W    = POINT_W + 1;
    localparam int S2_W      = POINT_W + 3;
    localparam int AREA_W    = MU_W + S2_W;
    localparam int HALF_W    = AREA_W / 2;
    localparam int PROD_W    = HALF_W + 1 + DIFF_W;
    localparam int ACC_W     = 64;
    localparam int DIV_W     = 64;
    localparam int DIV_NW    = $clog2(DIV_W + 1);
    localparam int MU_DIV_N  = DIFF_W + FRAC_W + 1;

    localparam logic [MU_W-1:0]    MU_ONE = MU_W'(1) << FRAC_W;
    localparam logic [POINT_W-1:0] P_MAX  = {1'b0, {(POINT_W-1){1'b1}}};
    localparam logic [POINT_W-1:0] P_MIN  = {1'b1, {(POINT_W-1){1'b0}}};

    typedef enum logic [OP_W-1:0] {
        OP_EVAL   = 3'd0,
        OP_ADD_IN = 3'd1,
        OP_ADD_V  = 3'd2,
        OP_ADD_C  = 3'd3,
        OP_RULE_V = 3'd4,
        OP_RULE_C = 3'd5
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd2;

    typedef struct packed {
        logic signed [POINT_W-1:0] a;
        logic signed [POINT_W-1:0] b;
        logic signed [POINT_W-1:0] c;
        logic signed [POINT_W-1:0] d;
    } t_trap;

    typedef struct packed {
        logic latch;
        logic load_exec;
        logic set_rd;
        logic mu_eval;
        logic mu_take;
        logic j_inc;
        logic k_clr;
        logic side_next;
        logic side_clr;
        logic rule_rd;
        logic out_rd;
        logic shape;
        logic area;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic fin_zero;
        logic fin_start;
        logic fin_take;
    } t_cmd;

    typedef struct packed {
        logic j_end;
        logic need_div;
        logic mu_zero;
        logic k_end;
        logic side;
        logic den_zero;
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
        logic [DIV_NW-1:0] nbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> design/ftc_div.sv
// unsigned restoring divider, one quotient bit per cycle
module ftc_div
    import ftc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_W-1:0]  r_num;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [DIV_NW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_W:0]    trial;
    logic              ge;
    logic [DIV_W:0]    diff;
    logic [DIV_NW-1:0] pre_shift;

    assign trial     = {r_rem, r_num[DIV_W-1]};
    assign ge        = trial >= {1'b0, r_div};
    assign diff      = trial - {1'b0, r_div};
    assign pre_shift = DIV_NW'(DIV_W) - i_req.nbits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_NW'(1);
                if (r_cnt == DIV_NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend << pre_shift;
            r_div <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_num <= {r_num[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

>>> design/ftc_dp.sv
// datapath: set and rule tables, membership, area accumulation, defuzzification
module ftc_dp
    import ftc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [POINT_W-1:0] i_point_a,
    input  logic signed [POINT_W-1:0] i_point_b,
    input  logic signed [POINT_W-1:0] i_point_c,
    input  logic signed [POINT_W-1:0] i_point_d,
    input  logic signed [POINT_W-1:0] i_temperature,
    input  logic signed [POINT_W-1:0] i_target,
    input  logic [RIDX_W-1:0]         i_rule_input_set,
    input  logic [RIDX_W-1:0]         i_rule_output_set,
    output t_stat                     o_stat,
    output logic signed [POINT_W-1:0] o_voltage,
    output logic signed [POINT_W-1:0] o_current,
    output logic [STAT_W-1:0]         o_status
);

    t_trap mem_in [IN_SETS];
    t_trap mem_v  [OUT_SETS];
    t_trap mem_c  [OUT_SETS];
    logic [OUT_IW-1:0] rule_v [IN_SETS*RULES];
    logic [OUT_IW-1:0] rule_c [IN_SETS*RULES];

    logic [OP_W-1:0]           r_op;
    t_trap                     r_item;
    logic [RIDX_W-1:0]         r_rin;
    logic [RIDX_W-1:0]         r_rout;
    logic signed [POINT_W-1:0] r_err;
    logic [CNT_W-1:0]          r_in_cnt;
    logic [OCNT_W-1:0]         r_v_cnt;
    logic [OCNT_W-1:0]         r_c_cnt;
    logic [RCNT_W-1:0]         r_vr_cnt [IN_SETS];
    logic [RCNT_W-1:0]         r_cr_cnt [IN_SETS];
    logic [CNT_W-1:0]          r_j;
    logic [RCNT_W-1:0]         r_k;
    logic                      r_side;
    t_trap                     r_in_set;
    logic [OUT_IW-1:0]         r_vt;
    logic [OUT_IW-1:0]         r_ct;
    t_trap                     r_vset;
    t_trap                     r_cset;
    logic [MU_W-1:0]           r_mu;
    logic [S2_W-1:0]           r_s2;
    logic signed [DIFF_W-1:0]  r_cen;
    logic [AREA_W-1:0]         r_area;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_vnum;
    logic signed [ACC_W-1:0]   r_cnum;
    logic [ACC_W-1:0]          r_vden;
    logic [ACC_W-1:0]          r_cden;
    logic signed [POINT_W-1:0] r_volt;
    logic signed [POINT_W-1:0] r_curr;
    logic [STAT_W-1:0]         r_status;

    t_div_req div_req;
    t_div_rsp div_rsp;

    ftc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // error of the incoming transaction
    logic signed [DIFF_W-1:0]  err_full;
    logic signed [POINT_W-1:0] err_sat;
    assign err_full = DIFF_W'(i_temperature) - DIFF_W'(i_target);
    always_comb begin
        if (err_full[DIFF_W-1] != err_full[DIFF_W-2]) begin
            err_sat = err_full[DIFF_W-1] ? P_MIN : P_MAX;
        end else begin
            err_sat = err_full[POINT_W-1:0];
        end
    end

    // load decode
    logic [IN_IW-1:0]  cidx;
    logic [RCNT_W-1:0] vr_sel;
    logic [RCNT_W-1:0] cr_sel;
    logic              we_in, we_v, we_c, we_rv, we_rc;
    logic [STAT_W-1:0] load_st;
    logic              bad_in;

    assign cidx   = (r_op == OP_EVAL) ? r_j[IN_IW-1:0] : r_rin[IN_IW-1:0];
    assign vr_sel = r_vr_cnt[cidx];
    assign cr_sel = r_cr_cnt[cidx];
    assign bad_in = CNT_W'(r_rin) >= r_in_cnt;

    always_comb begin
        we_in   = 1'b0;
        we_v    = 1'b0;
        we_c    = 1'b0;
        we_rv   = 1'b0;
        we_rc   = 1'b0;
        load_st = ST_OK;
        case (r_op)
            OP_ADD_IN: begin
                if (r_in_cnt >= CNT_W'(IN_SETS)) load_st = ST_FULL;
                else we_in = 1'b1;
            end
            OP_ADD_V: begin
                if (r_v_cnt >= OCNT_W'(OUT_SETS)) load_st = ST_FULL;
                else we_v = 1'b1;
            end
            OP_ADD_C: begin
                if (r_c_cnt >= OCNT_W'(OUT_SETS)) load_st = ST_FULL;
                else we_c = 1'b1;
            end
            OP_RULE_V: begin
                if (bad_in || OCNT_W'(r_rout) >= r_v_cnt) load_st = ST_BADIDX;
                else if (vr_sel >= RCNT_W'(RULES)) load_st = ST_FULL;
                else we_rv = 1'b1;
            end
            OP_RULE_C: begin
                if (bad_in || OCNT_W'(r_rout) >= r_c_cnt) load_st = ST_BADIDX;
                else if (cr_sel >= RCNT_W'(RULES)) load_st = ST_FULL;
                else we_rc = 1'b1;
            end
            default: load_st = ST_OK;
        endcase
    end

    // membership decision
    logic mu_zero_c, mu_one_c, mu_rise, mu_fall;
    logic signed [DIFF_W-1:0] x_a, b_a, d_x, d_c;
    assign x_a = DIFF_W'(r_err) - DIFF_W'(r_in_set.a);
    assign b_a = DIFF_W'(r_in_set.b) - DIFF_W'(r_in_set.a);
    assign d_x = DIFF_W'(r_in_set.d) - DIFF_W'(r_err);
    assign d_c = DIFF_W'(r_in_set.d) - DIFF_W'(r_in_set.c);

    always_comb begin
        mu_zero_c = 1'b0;
        mu_one_c  = 1'b0;
        mu_rise   = 1'b0;
        mu_fall   = 1'b0;
        if (r_err < r_in_set.a || r_err > r_in_set.d) begin
            mu_zero_c = 1'b1;
        end else if (r_err >= r_in_set.b && r_err <= r_in_set.c) begin
            mu_one_c = 1'b1;
        end else if (r_err <= r_in_set.b) begin
            if (r_in_set.a == r_in_set.b) mu_one_c = 1'b1;
            else mu_rise = 1'b1;
        end else if (r_in_set.c == r_in_set.d) begin
            mu_one_c = 1'b1;
        end else if (r_in_set.d < r_in_set.c) begin
            mu_zero_c = 1'b1;
        end else begin
            mu_fall = 1'b1;
        end
    end

    // shape of the selected output set
    t_trap                    oset;
    logic signed [DIFF_W-1:0] e1, e2, e3;
    logic [DIFF_W-1:0]        m1, m2, m3;
    assign oset = r_side ? r_cset : r_vset;
    assign e1   = DIFF_W'(oset.b) - DIFF_W'(oset.a);
    assign e2   = DIFF_W'(oset.c) - DIFF_W'(oset.b);
    assign e3   = DIFF_W'(oset.d) - DIFF_W'(oset.c);
    assign m1   = e1[DIFF_W-1] ? DIFF_W'(-e1) : DIFF_W'(e1);
    assign m2   = e2[DIFF_W-1] ? DIFF_W'(-e2) : DIFF_W'(e2);
    assign m3   = e3[DIFF_W-1] ? DIFF_W'(-e3) : DIFF_W'(e3);

    logic signed [HALF_W:0]  area_lo;
    logic signed [HALF_W:0]  area_hi;
    logic signed [ACC_W-1:0] prod_ext;
    assign area_lo  = $signed({1'b0, r_area[HALF_W-1:0]});
    assign area_hi  = $signed({1'b0, r_area[AREA_W-1:HALF_W]});
    assign prod_ext = ACC_W'(r_prod);

    // final division operands
    logic signed [ACC_W-1:0] fnum;
    logic [ACC_W-1:0]        fden;
    logic [ACC_W-1:0]        fmag;
    logic                    fneg;
    logic [POINT_W-1:0]      fsat;
    assign fnum = r_side ? r_cnum : r_vnum;
    assign fden = r_side ? r_cden : r_vden;
    assign fneg = fnum[ACC_W-1];
    assign fmag = fneg ? ACC_W'(-fnum) : ACC_W'(fnum);

    always_comb begin
        if (!fneg) begin
            fsat = (div_rsp.quot > DIV_W'(P_MAX)) ? P_MAX : div_rsp.quot[POINT_W-1:0];
        end else if (div_rsp.quot > DIV_W'({1'b0, P_MIN})) begin
            fsat = P_MIN;
        end else begin
            fsat = POINT_W'(-div_rsp.quot[POINT_W-1:0]);
        end
    end

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        div_req.nbits    = DIV_NW'(MU_DIV_N);
        if (i_cmd.fin_start) begin
            div_req.start    = 1'b1;
            div_req.dividend = fmag;
            div_req.divisor  = {fden[ACC_W-2:0], 1'b0};
            div_req.nbits    = DIV_NW'(DIV_W);
        end else if (i_cmd.mu_eval && mu_rise) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({x_a, {FRAC_W{1'b0}}});
            div_req.divisor  = DIV_W'(b_a);
        end else if (i_cmd.mu_eval && mu_fall) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'({d_x, {FRAC_W{1'b0}}});
            div_req.divisor  = DIV_W'(d_c);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op     <= OP_EVAL;
            r_in_cnt <= '0;
            r_v_cnt  <= '0;
            r_c_cnt  <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_side   <= 1'b0;
            for (int i = 0; i < IN_SETS; i++) begin
                r_vr_cnt[i] <= '0;
                r_cr_cnt[i] <= '0;
            end
        end else begin
            if (i_cmd.latch) begin
                r_op <= i_opcode;
                r_j  <= '0;
            end
            if (i_cmd.load_exec) begin
                if (we_in) r_in_cnt <= r_in_cnt + CNT_W'(1);
                if (we_v)  r_v_cnt  <= r_v_cnt + OCNT_W'(1);
                if (we_c)  r_c_cnt  <= r_c_cnt + OCNT_W'(1);
                if (we_rv) r_vr_cnt[cidx] <= vr_sel + RCNT_W'(1);
                if (we_rc) r_cr_cnt[cidx] <= cr_sel + RCNT_W'(1);
            end
            if (i_cmd.j_inc) r_j <= r_j + CNT_W'(1);
            if (i_cmd.k_clr) begin
                r_k    <= '0;
                r_side <= 1'b0;
            end
            if (i_cmd.side_next) begin
                r_k    <= '0;
                r_side <= 1'b1;
            end
            if (i_cmd.side_clr) r_side <= 1'b0;
            if (i_cmd.acc) r_k <= r_k + RCNT_W'(1);
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_exec && we_in) mem_in[r_in_cnt[IN_IW-1:0]] <= r_item;
        if (i_cmd.load_exec && we_v)  mem_v[r_v_cnt[OUT_IW-1:0]]  <= r_item;
        if (i_cmd.load_exec && we_c)  mem_c[r_c_cnt[OUT_IW-1:0]]  <= r_item;
        if (i_cmd.load_exec && we_rv) begin
            rule_v[{cidx, vr_sel[RULE_IW-1:0]}] <= r_rout[OUT_IW-1:0];
        end
        if (i_cmd.load_exec && we_rc) begin
            rule_c[{cidx, cr_sel[RULE_IW-1:0]}] <= r_rout[OUT_IW-1:0];
        end
        if (i_cmd.set_rd) r_in_set <= mem_in[r_j[IN_IW-1:0]];
        if (i_cmd.rule_rd) begin
            r_vt <= rule_v[{r_j[IN_IW-1:0], r_k[RULE_IW-1:0]}];
            r_ct <= rule_c[{r_j[IN_IW-1:0], r_k[RULE_IW-1:0]}];
        end
        if (i_cmd.out_rd) begin
            r_vset <= mem_v[r_vt];
            r_cset <= mem_c[r_ct];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item   <= '{a: i_point_a, b: i_point_b, c: i_point_c, d: i_point_d};
            r_rin    <= i_rule_input_set;
            r_rout   <= i_rule_output_set;
            r_err    <= err_sat;
            r_vnum   <= '0;
            r_cnum   <= '0;
            r_vden   <= '0;
            r_cden   <= '0;
            r_volt   <= '0;
            r_curr   <= '0;
            r_status <= ST_OK;
        end
        if (i_cmd.load_exec) r_status <= load_st;
        if (i_cmd.mu_eval)   r_mu <= mu_one_c ? MU_ONE : '0;
        if (i_cmd.mu_take)   r_mu <= div_rsp.quot[MU_W-1:0];
        if (i_cmd.shape) begin
            r_s2  <= S2_W'(m1) + S2_W'({m2, 1'b0}) + S2_W'(m3);
            r_cen <= DIFF_W'(oset.a) + DIFF_W'(oset.d);
        end
        if (i_cmd.area) r_area <= AREA_W'(r_mu) * AREA_W'(r_s2);
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(area_lo) * PROD_W'(r_cen);
            if (r_side) r_cden <= r_cden + ACC_W'(r_area);
            else        r_vden <= r_vden + ACC_W'(r_area);
        end
        if (i_cmd.mul_hi) begin
            r_prod <= PROD_W'(area_hi) * PROD_W'(r_cen);
            if (r_side) r_cnum <= r_cnum + prod_ext;
            else        r_vnum <= r_vnum + prod_ext;
        end
        if (i_cmd.acc) begin
            if (r_side) r_cnum <= r_cnum + (prod_ext <<< HALF_W);
            else        r_vnum <= r_vnum + (prod_ext <<< HALF_W);
        end
        if (i_cmd.fin_zero || i_cmd.fin_take) begin
            if (r_side) r_curr <= i_cmd.fin_take ? fsat : '0;
            else        r_volt <= i_cmd.fin_take ? fsat : '0;
        end
    end

    assign o_stat.j_end    = r_j >= r_in_cnt;
    assign o_stat.need_div = mu_rise | mu_fall;
    assign o_stat.mu_zero  = r_mu == '0;
    assign o_stat.k_end    = r_k >= (r_side ? cr_sel : vr_sel);
    assign o_stat.side     = r_side;
    assign o_stat.den_zero = fden == '0;
    assign o_stat.div_done = div_rsp.done;

    assign o_voltage = r_volt;
    assign o_current = r_curr;
    assign o_status  = r_status;

endmodule

>>> design/ftc_ctrl.sv
// controller state machine sequencing loads and evaluation
module ftc_ctrl
    import ftc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [OP_W-1:0] i_opcode,
    input  t_stat           i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_LOAD     = 16'h0002,
        S_SET_RD   = 16'h0004,
        S_MEM      = 16'h0008,
        S_MU_WAIT  = 16'h0010,
        S_MU_CHK   = 16'h0020,
        S_RULE_RD  = 16'h0040,
        S_OUT_RD   = 16'h0080,
        S_SHAPE    = 16'h0100,
        S_AREA     = 16'h0200,
        S_MUL_LO   = 16'h0400,
        S_MUL_HI   = 16'h0800,
        S_ACC      = 16'h1000,
        S_FIN      = 16'h2000,
        S_FIN_WAIT = 16'h4000,
        S_DONE     = 16'h8000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_opcode == OP_EVAL) ? S_SET_RD : S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load_exec = 1'b1;
                n_state = S_DONE;
            end
            S_SET_RD: begin
                if (i_stat.j_end) begin
                    o_cmd.side_clr = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.set_rd = 1'b1;
                    n_state = S_MEM;
                end
            end
            S_MEM: begin
                o_cmd.mu_eval = 1'b1;
                n_state = i_stat.need_div ? S_MU_WAIT : S_MU_CHK;
            end
            S_MU_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.mu_take = 1'b1;
                    n_state = S_MU_CHK;
                end
            end
            S_MU_CHK: begin
                if (i_stat.mu_zero) begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_SET_RD;
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state = S_RULE_RD;
                end
            end
            S_RULE_RD: begin
                if (!i_stat.k_end) begin
                    o_cmd.rule_rd = 1'b1;
                    n_state = S_OUT_RD;
                end else if (!i_stat.side) begin
                    o_cmd.side_next = 1'b1;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state = S_SET_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_SHAPE;
            end
            S_SHAPE: begin
                o_cmd.shape = 1'b1;
                n_state = S_AREA;
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = S_RULE_RD;
            end
            S_FIN: begin
                if (i_stat.den_zero) begin
                    o_cmd.fin_zero = 1'b1;
                    if (i_stat.side) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.side_next = 1'b1;
                    end
                end else begin
                    o_cmd.fin_start = 1'b1;
                    n_state = S_FIN_WAIT;
                end
            end
            S_FIN_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.fin_take = 1'b1;
                    if (i_stat.side) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.side_next = 1'b1;
                        n_state = S_FIN;
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_state == S_DONE;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state register not one-hot");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("transaction accepted without going busy");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_MU_WAIT || r_state == S_FIN_WAIT))
        else $error("divider finished outside a wait state");

endmodule

>>> design/fuzzy_trapezoid_controller.sv
// top level of the fuzzy trapezoid controller
//
// channel   direction  handshake                 payload
// command   in         start high, busy low      opcode, points a-d, temperature, target,
//                                                rule input and output set
// result    out        o_valid one-cycle strobe  voltage, current, status
//
// load: S_LOAD writes table and status, S_DONE strobes, then S_IDLE accepts again
// evaluate: each loaded input set is read and its membership taken, with the divider when
//   an edge needs it; each rule of a set with nonzero membership is read, shaped, weighed
//   and summed; each output of nonzero area ends in a one-bit-per-cycle 64-bit division
// synchronous active-low reset clears all counts; tables need no clearing
// busy stays high from accept through the strobe cycle; the receiver cannot stall results
module fuzzy_trapezoid_controller
    import ftc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [POINT_W-1:0] i_point_a,
    input  logic signed [POINT_W-1:0] i_point_b,
    input  logic signed [POINT_W-1:0] i_point_c,
    input  logic signed [POINT_W-1:0] i_point_d,
    input  logic signed [POINT_W-1:0] i_temperature,
    input  logic signed [POINT_W-1:0] i_target,
    input  logic [RIDX_W-1:0]         i_rule_input_set,
    input  logic [RIDX_W-1:0]         i_rule_output_set,
    output logic                      o_valid,
    output logic signed [POINT_W-1:0] o_voltage,
    output logic signed [POINT_W-1:0] o_current,
    output logic [STAT_W-1:0]         o_status
);

    t_cmd  cmd;
    t_stat stat;

    ftc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    ftc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_opcode          (i_opcode),
        .i_point_a         (i_point_a),
        .i_point_b         (i_point_b),
        .i_point_c         (i_point_c),
        .i_point_d         (i_point_d),
        .i_temperature     (i_temperature),
        .i_target          (i_target),
        .i_rule_input_set  (i_rule_input_set),
        .i_rule_output_set (i_rule_output_set),
        .o_stat            (stat),
        .o_voltage         (o_voltage),
        .o_current         (o_current),
        .o_status          (o_status)
    );

endmodule

>>> tb/tb_fuzzy_trapezoid_controller.sv
// self-checking testbench of the fuzzy trapezoid controller with a tracking scoreboard
module tb_fuzzy_trapezoid_controller;
    import ftc_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [POINT_W-1:0] pa, pb, pc, pd, temp, tgt;
        logic [RIDX_W-1:0]         ri, ro;
    } t_cmd_item;

    typedef struct {
        logic signed [POINT_W-1:0] volt, curr;
        logic [STAT_W-1:0]         stat;
    } t_answer;

    class ctrl_scoreboard;
        t_trap    in_tab[IN_SETS], v_tab[OUT_SETS], c_tab[OUT_SETS];
        int       in_n, v_n, c_n;
        int       v_rc[IN_SETS], c_rc[IN_SETS];
        int       v_rt[IN_SETS][RULES], c_rt[IN_SETS][RULES];
        t_answer  pending[$];
        bit       failed;

        function longint sat(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function longint degree(t_trap t, longint x);
            longint a, b, c, d;
            a = longint'(t.a); b = longint'(t.b); c = longint'(t.c); d = longint'(t.d);
            if (x < a || x > d) return 0;
            if (x >= b && x <= c) return 65536;
            if (x >= a && x <= b) begin
                if (a == b) return 65536;
                return ((x - a) * 65536) / (b - a);
            end
            if (c == d) return 65536;
            if (d < c) return 0;
            return ((d - x) * 65536) / (d - c);
        endfunction

        function void weigh(t_trap t, longint mu, inout longint num, inout longint den);
            longint ab, cb, dc, area;
            ab = longint'(t.b) - t.a; cb = longint'(t.c) - t.b; dc = longint'(t.d) - t.c;
            if (ab < 0) ab = -ab;
            if (cb < 0) cb = -cb;
            if (dc < 0) dc = -dc;
            area = mu * (ab + 2 * cb + dc);
            den += area;
            num += area * (longint'(t.a) + t.d);
        endfunction

        function longint centroid(longint num, longint den);
            if (den == 0) return 0;
            return sat(num / (2 * den));
        endfunction

        function t_trap pack_trap(t_cmd_item c);
            t_trap t;
            t.a = c.pa; t.b = c.pb; t.c = c.pc; t.d = c.pd;
            return t;
        endfunction

        function void note(t_cmd_item c);
            t_answer r;
            longint err, mu, vn, vd, cn, cd;
            r.volt = 0; r.curr = 0; r.stat = ST_OK;
            case (c.op)
                OP_EVAL: begin
                    err = sat(longint'(c.temp) - c.tgt);
                    vn = 0; vd = 0; cn = 0; cd = 0;
                    for (int j = 0; j < in_n; j++) begin
                        mu = degree(in_tab[j], err);
                        if (mu == 0) continue;
                        for (int k = 0; k < v_rc[j]; k++) weigh(v_tab[v_rt[j][k]], mu, vn, vd);
                        for (int k = 0; k < c_rc[j]; k++) weigh(c_tab[c_rt[j][k]], mu, cn, cd);
                    end
                    r.volt = POINT_W'(centroid(vn, vd));
                    r.curr = POINT_W'(centroid(cn, cd));
                end
                OP_ADD_IN: if (in_n >= IN_SETS) r.stat = ST_FULL;
                           else in_tab[in_n++] = pack_trap(c);
                OP_ADD_V:  if (v_n >= OUT_SETS) r.stat = ST_FULL;
                           else v_tab[v_n++] = pack_trap(c);
                OP_ADD_C:  if (c_n >= OUT_SETS) r.stat = ST_FULL;
                           else c_tab[c_n++] = pack_trap(c);
                OP_RULE_V: if (c.ri >= in_n || c.ro >= v_n) r.stat = ST_BADIDX;
                           else if (v_rc[c.ri] >= RULES) r.stat = ST_FULL;
                           else v_rt[c.ri][v_rc[c.ri]++] = int'(c.ro);
                OP_RULE_C: if (c.ri >= in_n || c.ro >= c_n) r.stat = ST_BADIDX;
                           else if (c_rc[c.ri] >= RULES) r.stat = ST_FULL;
                           else c_rt[c.ri][c_rc[c.ri]++] = int'(c.ro);
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check(logic signed [POINT_W-1:0] volt, logic signed [POINT_W-1:0] curr,
                            logic [STAT_W-1:0] stat);
            t_answer e;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                failed = 1;
                return;
            end
            e = pending.pop_front();
            if (volt !== e.volt) begin
                $error("voltage expected %0d actual %0d", e.volt, volt); failed = 1;
            end
            if (curr !== e.curr) begin
                $error("current expected %0d actual %0d", e.curr, curr); failed = 1;
            end
            if (stat !== e.stat) begin
                $error("status expected %0d actual %0d", e.stat, stat); failed = 1;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           i_opcode;
    logic signed [POINT_W-1:0] i_point_a, i_point_b, i_point_c, i_point_d;
    logic signed [POINT_W-1:0] i_temperature, i_target;
    logic [RIDX_W-1:0]         i_rule_input_set, i_rule_output_set;
    logic                      o_valid;
    logic signed [POINT_W-1:0] o_voltage, o_current;
    logic [STAT_W-1:0]         o_status;

    ctrl_scoreboard sb;

    fuzzy_trapezoid_controller u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_point_a(i_point_a), .i_point_b(i_point_b),
        .i_point_c(i_point_c), .i_point_d(i_point_d), .i_temperature(i_temperature),
        .i_target(i_target), .i_rule_input_set(i_rule_input_set),
        .i_rule_output_set(i_rule_output_set), .o_valid(o_valid),
        .o_voltage(o_voltage), .o_current(o_current), .o_status(o_status)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check(o_voltage, o_current, o_status);
    end

    task automatic send(t_cmd_item c);
        int n;
        i_opcode <= c.op;
        i_point_a <= c.pa; i_point_b <= c.pb; i_point_c <= c.pc; i_point_d <= c.pd;
        i_temperature <= c.temp; i_target <= c.tgt;
        i_rule_input_set <= c.ri; i_rule_output_set <= c.ro;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.note(c);
        n = $urandom_range(0, 19);
        if (n < 11) n = 0;
        else if (n < 18) n = $urandom_range(1, 5);
        else n = $urandom_range(20, 150);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_cmd_item mk(logic [OP_W-1:0] op, int a, int b, int c, int d,
                                     int temp, int tgt, int ri, int ro);
        t_cmd_item x;
        x.op = op;
        x.pa = POINT_W'(a); x.pb = POINT_W'(b); x.pc = POINT_W'(c); x.pd = POINT_W'(d);
        x.temp = POINT_W'(temp); x.tgt = POINT_W'(tgt);
        x.ri = RIDX_W'(ri); x.ro = RIDX_W'(ro);
        return x;
    endfunction

    function automatic t_cmd_item rand_trap(logic [OP_W-1:0] op);
        int p[4], s, span, m;
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(64, 4096);
        for (int i = 0; i < 4; i++) p[i] = $urandom_range(0, 2 * span) - span;
        m = $urandom_range(0, 9);
        if (m < 8) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3 - i; j++)
                    if (p[j] > p[j+1]) begin s = p[j]; p[j] = p[j+1]; p[j+1] = s; end
            if (m == 1) p[1] = p[0];
            if (m == 2) p[3] = p[2];
        end
        return mk(op, p[0], p[1], p[2], p[3], $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic t_cmd_item rand_item();
        t_cmd_item x;
        int r, j, lo, hi, e;
        r = $urandom_range(0, 99);
        if (r < 10) x = rand_trap(OP_ADD_IN);
        else if (r < 17) x = rand_trap(OP_ADD_V);
        else if (r < 24) x = rand_trap(OP_ADD_C);
        else if (r < 40) begin
            x = mk((r < 32) ? OP_RULE_V : OP_RULE_C, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
            if ($urandom_range(0, 4) != 0) begin
                if (sb.in_n > 0) x.ri = RIDX_W'($urandom_range(0, sb.in_n - 1));
                if (x.op == OP_RULE_V && sb.v_n > 0) x.ro = RIDX_W'($urandom_range(0, sb.v_n - 1));
                if (x.op == OP_RULE_C && sb.c_n > 0) x.ro = RIDX_W'($urandom_range(0, sb.c_n - 1));
            end
        end else if (r < 95) begin
            x = mk(OP_EVAL, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
            if (sb.in_n > 0 && $urandom_range(0, 4) != 0) begin
                j = $urandom_range(0, sb.in_n - 1);
                lo = int'(sb.in_tab[j].a); hi = int'(sb.in_tab[j].d);
                if (hi < lo) begin e = lo; lo = hi; hi = e; end
                e = lo + $urandom_range(0, hi - lo);
                lo = (e < 0) ? -32768 - e : -32768;
                hi = (e > 0) ? 32767 - e : 32767;
                x.tgt = POINT_W'(lo + $urandom_range(0, hi - lo));
                x.temp = POINT_W'(int'(x.tgt) + e);
            end
        end else begin
            x = mk((r < 97) ? OP_SPARE_LO : OP_SPARE_HI, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        return x;
    endfunction

    initial begin
        int guard;
        sb = new();
        i_rst_n = 0; start = 0; i_opcode = OP_EVAL;
        i_point_a = 0; i_point_b = 0; i_point_c = 0; i_point_d = 0;
        i_temperature = 0; i_target = 0; i_rule_input_set = 0; i_rule_output_set = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(mk(OP_EVAL, 0, 0, 0, 0, 100, 0, 0, 0));
        send(mk(OP_RULE_V, 0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_ADD_IN, -256, 0, 0, 256, 0, 0, 0, 0));
        send(mk(OP_ADD_IN, 0, 0, 256, 512, 0, 0, 0, 0));
        send(mk(OP_ADD_IN, -512, -256, -128, -128, 0, 0, 0, 0));
        send(mk(OP_ADD_IN, 0, 256, 512, 300, 0, 0, 0, 0));
        send(mk(OP_ADD_IN, -32768, -100, 100, 32767, 0, 0, 0, 0));
        send(mk(OP_ADD_V, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        send(mk(OP_ADD_V, 100, 200, 300, 400, 0, 0, 0, 0));
        send(mk(OP_ADD_C, 32767, 0, -32768, 5, 0, 0, 0, 0));
        send(mk(OP_ADD_C, -1000, -500, -500, 0, 0, 0, 0, 0));
        send(mk(OP_RULE_C, 0, 0, 0, 0, 0, 0, 7, 0));
        send(mk(OP_RULE_V, 0, 0, 0, 0, 0, 0, 0, 7));
        for (int i = 0; i < 5; i++) begin
            send(mk(OP_RULE_V, 0, 0, 0, 0, 0, 0, i, i % 2));
            send(mk(OP_RULE_C, 0, 0, 0, 0, 0, 0, i, (i + 1) % 2));
        end
        send(mk(OP_EVAL, 0, 0, 0, 0, 32767, -32768, 0, 0));
        send(mk(OP_EVAL, 0, 0, 0, 0, -32768, 32767, 0, 0));
        send(mk(OP_EVAL, 0, 0, 0, 0, 128, 0, 0, 0));
        send(mk(OP_EVAL, 0, 0, 0, 0, 400, 0, 0, 0));
        send(mk(OP_EVAL, 0, 0, 0, 0, -300, 0, 0, 0));
        send(mk(OP_SPARE_LO, -1, -1, -1, -1, -1, -1, 7, 7));
        send(mk(OP_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0));

        for (int n = 0; n < 1500; n++) begin
            if (n == 700) begin
                start <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            send(rand_item());
        end
        start <= 1'b0;

        guard = 0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            $error("%0d results never arrived", sb.pending.size());
            sb.failed = 1;
        end
        if (!sb.failed) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
